### design/assert_macros.svh
// assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // command codes
    typedef enum logic [2:0] {
        ACT_INSERT  = 3'd0,
        ACT_RM_HIGH = 3'd1,
        ACT_RM_LOW  = 3'd2,
        ACT_FIND    = 3'd3,
        ACT_DELETE  = 3'd4
    } t_action;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NO_NAME   = 3'd4;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_PUT,
        S_FIN
    } t_state;

    // one stored entry
    typedef struct packed {
        logic signed [31:0] pri;
        logic [63:0]        name;
    } t_entry;

    // command transaction
    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] entry_priority;
        logic [63:0]        key_name;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_priority;
        logic [63:0]        out_name;
        logic [4:0]         entry_count;
    } t_out;

endpackage

`default_nettype wire

### design/spq_mem.sv
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output spq_pkg::t_entry               o_rdata,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire spq_pkg::t_entry          i_wdata
);

    spq_pkg::t_entry r_mem [DEPTH];
    spq_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: walks the entry store one slot per read/execute pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int NAME_BYTES = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cmd_valid,
    output logic                          o_cmd_ready,
    input  wire spq_pkg::t_in             i_cmd,
    output logic                          o_res_valid,
    input  wire logic                     i_res_ready,
    output spq_pkg::t_out                 o_res,
    output logic [$clog2(DEPTH)-1:0]      o_raddr,
    input  wire spq_pkg::t_entry          i_rdata,
    output logic                          o_we,
    output logic [$clog2(DEPTH)-1:0]      o_waddr,
    output spq_pkg::t_entry               o_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [63:0] NMASK = (NAME_BYTES >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

    spq_pkg::t_state    r_state, n_state;
    spq_pkg::t_action   r_op, n_op;
    logic signed [31:0] r_pri, n_pri;
    logic [63:0]        r_name, n_name;
    logic [AW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_wr, n_wr;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_hit, n_hit;
    logic [2:0]         r_status, n_status;
    logic signed [31:0] r_res_pri, n_res_pri;
    logic [63:0]        r_res_name, n_res_name;

    logic [63:0]        w_key;
    logic               w_nm_zero;
    logic               w_full;
    logic               w_empty;
    logic [CW-1:0]      w_cnt_m1;
    logic               w_last;
    logic               w_ge;
    logic               w_match;
    logic               w_skip;
    logic               w_accept;
    logic [CW+4:0]      w_cnt_ext;

    // shared decode
    assign w_key     = i_cmd.key_name & NMASK;
    assign w_nm_zero = (w_key == 64'd0);
    assign w_full    = (r_cnt == CW'(DEPTH));
    assign w_empty   = (r_cnt == CW'(0));
    assign w_cnt_m1  = r_cnt - CW'(1);
    assign w_last    = (r_idx == w_cnt_m1[AW-1:0]);
    assign w_ge      = (i_rdata.pri >= r_pri);
    assign w_match   = (i_rdata.name == r_name);
    assign w_skip    = (r_op == spq_pkg::ACT_RM_HIGH) ? (r_idx == AW'(0)) : w_match;
    assign w_accept  = i_cmd_valid && o_cmd_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.action)
                        spq_pkg::ACT_INSERT: begin
                            if (w_nm_zero || w_full) begin
                                n_state = spq_pkg::S_FIN;
                            end else if (w_empty) begin
                                n_state = spq_pkg::S_PUT;
                            end else begin
                                n_state = spq_pkg::S_RD;
                            end
                        end
                        spq_pkg::ACT_RM_HIGH, spq_pkg::ACT_RM_LOW: begin
                            n_state = w_empty ? spq_pkg::S_FIN : spq_pkg::S_RD;
                        end
                        spq_pkg::ACT_FIND, spq_pkg::ACT_DELETE: begin
                            n_state = (w_nm_zero || w_empty) ? spq_pkg::S_FIN
                                                             : spq_pkg::S_RD;
                        end
                        default: n_state = spq_pkg::S_FIN;
                    endcase
                end
            end
            spq_pkg::S_RD: n_state = spq_pkg::S_EX;
            spq_pkg::S_EX: begin
                case (r_op)
                    spq_pkg::ACT_INSERT: begin
                        if (w_ge || r_idx == AW'(0)) begin
                            n_state = spq_pkg::S_PUT;
                        end else begin
                            n_state = spq_pkg::S_RD;
                        end
                    end
                    spq_pkg::ACT_RM_LOW: n_state = spq_pkg::S_FIN;
                    spq_pkg::ACT_FIND: begin
                        n_state = (w_match || w_last) ? spq_pkg::S_FIN : spq_pkg::S_RD;
                    end
                    default: n_state = w_last ? spq_pkg::S_FIN : spq_pkg::S_RD;
                endcase
            end
            spq_pkg::S_PUT: n_state = spq_pkg::S_FIN;
            spq_pkg::S_FIN: begin
                if (i_res_ready) begin
                    n_state = spq_pkg::S_IDLE;
                end
            end
            default: n_state = spq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op       = r_op;
        n_pri      = r_pri;
        n_name     = r_name;
        n_idx      = r_idx;
        n_wr       = r_wr;
        n_cnt      = r_cnt;
        n_hit      = r_hit;
        n_status   = r_status;
        n_res_pri  = r_res_pri;
        n_res_name = r_res_name;
        o_cmd_ready = (r_state == spq_pkg::S_IDLE);
        o_res_valid = (r_state == spq_pkg::S_FIN);
        o_raddr    = r_idx;
        o_we       = 1'b0;
        o_waddr    = r_idx;
        o_wdata    = i_rdata;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op       = spq_pkg::t_action'(i_cmd.action);
                    n_pri      = i_cmd.entry_priority;
                    n_name     = w_key;
                    n_idx      = AW'(0);
                    n_wr       = CW'(0);
                    n_hit      = 1'b0;
                    n_status   = spq_pkg::ST_OK;
                    n_res_pri  = 32'sd0;
                    n_res_name = 64'd0;
                    case (i_cmd.action)
                        spq_pkg::ACT_INSERT: begin
                            if (w_nm_zero) begin
                                n_status = spq_pkg::ST_NO_NAME;
                            end else if (w_full) begin
                                n_status = spq_pkg::ST_FULL;
                            end else begin
                                n_idx = w_cnt_m1[AW-1:0];
                            end
                        end
                        spq_pkg::ACT_RM_HIGH, spq_pkg::ACT_RM_LOW: begin
                            if (w_empty) begin
                                n_status = spq_pkg::ST_EMPTY;
                            end else if (i_cmd.action == spq_pkg::ACT_RM_LOW) begin
                                n_idx = w_cnt_m1[AW-1:0];
                            end
                        end
                        spq_pkg::ACT_FIND, spq_pkg::ACT_DELETE: begin
                            if (w_nm_zero) begin
                                n_status = spq_pkg::ST_NO_NAME;
                            end else if (w_empty) begin
                                n_status = spq_pkg::ST_EMPTY;
                            end
                        end
                        default: n_status = spq_pkg::ST_OK;
                    endcase
                end
            end
            spq_pkg::S_EX: begin
                case (r_op)
                    // walk down from the tail, shifting smaller entries up
                    spq_pkg::ACT_INSERT: begin
                        if (w_ge) begin
                            n_wr = CW'(r_idx) + CW'(1);
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = r_idx + AW'(1);
                            if (r_idx == AW'(0)) begin
                                n_wr = CW'(0);
                            end else begin
                                n_idx = r_idx - AW'(1);
                            end
                        end
                    end
                    spq_pkg::ACT_RM_LOW: begin
                        n_res_pri  = i_rdata.pri;
                        n_res_name = i_rdata.name;
                        n_cnt      = w_cnt_m1;
                    end
                    spq_pkg::ACT_FIND: begin
                        if (w_match) begin
                            n_res_pri  = i_rdata.pri;
                            n_res_name = i_rdata.name;
                        end else if (w_last) begin
                            n_status = spq_pkg::ST_NOT_FOUND;
                        end else begin
                            n_idx = r_idx + AW'(1);
                        end
                    end
                    // compaction pass: skipped entries drop out
                    default: begin
                        if (w_skip) begin
                            if (!r_hit) begin
                                n_res_pri  = i_rdata.pri;
                                n_res_name = i_rdata.name;
                            end
                            n_hit = 1'b1;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = r_wr[AW-1:0];
                            n_wr    = r_wr + CW'(1);
                        end
                        if (w_last) begin
                            n_cnt    = w_skip ? r_wr : r_wr + CW'(1);
                            n_status = (r_hit || w_skip) ? spq_pkg::ST_OK
                                                         : spq_pkg::ST_NOT_FOUND;
                        end else begin
                            n_idx = r_idx + AW'(1);
                        end
                    end
                endcase
            end
            spq_pkg::S_PUT: begin
                o_we         = 1'b1;
                o_waddr      = r_wr[AW-1:0];
                o_wdata.pri  = r_pri;
                o_wdata.name = r_name;
                n_cnt        = r_cnt + CW'(1);
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pri      <= n_pri;
        r_name     <= n_name;
        r_idx      <= n_idx;
        r_wr       <= n_wr;
        r_hit      <= n_hit;
        r_status   <= n_status;
        r_res_pri  <= n_res_pri;
        r_res_name <= n_res_name;
    end

    // result fields
    assign w_cnt_ext          = (CW + 5)'(r_cnt);
    assign o_res.status       = r_status;
    assign o_res.out_priority = r_res_pri;
    assign o_res.out_name     = r_res_name;
    assign o_res.entry_count  = w_cnt_ext[4:0];

endmodule

`default_nettype wire

### design/sorted_priority_queue.sv
// Sorted priority queue: holds up to DEPTH entries (signed priority and name)
// in one memory sorted from highest to lowest priority, and runs one command
// at a time. Every slot visit is a memory read followed by an execute state,
// so a command is taken in the idle state, walks its slots one at a time
// through the single read port of the entry store, does an insert's write in
// the put state, and ends in the result state. The result shows on the
// outputs in the cycle after it leaves the result state. The next command is
// taken while a result still waits in the output register. No clearing pass
// after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH      = 16,
    parameter int NAME_BYTES = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire spq_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output spq_pkg::t_out     o_out_data
);

    localparam int AW = $clog2(DEPTH);

    logic            w_res_valid;
    logic            w_res_ready;
    spq_pkg::t_out   w_res;
    logic [AW-1:0]   w_raddr;
    logic [AW-1:0]   w_waddr;
    logic            w_we;
    spq_pkg::t_entry w_rdata;
    spq_pkg::t_entry w_wdata;
    logic            r_out_valid;
    spq_pkg::t_out   r_out_data;

    spq_ctrl #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_in_valid),
        .o_cmd_ready (o_in_ready),
        .i_cmd       (i_in_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata)
    );

    spq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata)
    );

    // output register
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue's result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spq_checker #(
    parameter int DEPTH = 16
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire spq_pkg::t_out o_out_data
);

    // a pending result transaction is not dropped
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid, "result dropped")

    // status is a defined code
    `ASSERT_CLK(a_status_code, i_clk, i_rst_n,
        o_out_valid |-> (o_out_data.status == spq_pkg::ST_OK ||
            o_out_data.status == spq_pkg::ST_EMPTY ||
            o_out_data.status == spq_pkg::ST_NOT_FOUND ||
            o_out_data.status == spq_pkg::ST_FULL ||
            o_out_data.status == spq_pkg::ST_NO_NAME), "bad status")

    // failed commands carry no entry
    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.status != spq_pkg::ST_OK |->
            o_out_data.out_priority == 32'sd0 && o_out_data.out_name == 64'd0,
        "entry on failure")

    // count never exceeds capacity
    `ASSERT_CLK(a_count_max, i_clk, i_rst_n,
        o_out_valid |-> (DEPTH > 31) || (int'(o_out_data.entry_count) <= DEPTH),
        "count too large")

    // no result right out of reset
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "result during reset")

endmodule

bind sorted_priority_queue spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
